// ===== src/mcps_pkg.sv =====
// mcps_pkg: shared types and constants for the periodic channel scheduler.
// Used by mcps_ctrl, mcps_dp and multi_channel_period_scheduler_top.
`default_nettype none
package mcps_pkg;

  localparam int unsigned PERIOD_W = 24;
  localparam int unsigned ID_W     = 5;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIN,
    ST_MIN_END,
    ST_SUB_RD,
    ST_SUB_CHK,
    ST_FLUSH,
    ST_EMPTY
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic adv_start;
    logic sub_start;
    logic idx_inc;
    logic min_step;
    logic sub_rd;
    logic sub_commit;
    logic flush;
    logic emit_empty;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic idx_last;
    logic cur_valid;
    logic any;
    logic can_commit;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/mcps_ctrl.sv =====
// mcps_ctrl: sequencer for load and advance items.
// Depends on mcps_pkg (state_t, cmd_t, sts_t, kind codes).
`default_nettype none
module mcps_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  input  wire              in_kind,
  output logic             in_ready,
  input  mcps_pkg::sts_t   sts,
  output mcps_pkg::cmd_t   cmd
);

  mcps_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcps_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mcps_pkg::ST_IDLE: begin
        if (in_valid && in_kind == mcps_pkg::KIND_ADVANCE) begin
          state_nxt = mcps_pkg::ST_MIN;
        end
      end
      mcps_pkg::ST_MIN: begin
        if (sts.idx_last) begin
          state_nxt = mcps_pkg::ST_MIN_END;
        end
      end
      mcps_pkg::ST_MIN_END: state_nxt = mcps_pkg::ST_SUB_RD;
      mcps_pkg::ST_SUB_RD: begin
        if (!sts.any) begin
          state_nxt = mcps_pkg::ST_EMPTY;
        end else if (sts.cur_valid) begin
          state_nxt = mcps_pkg::ST_SUB_CHK;
        end else if (sts.idx_last) begin
          state_nxt = mcps_pkg::ST_FLUSH;
        end
      end
      mcps_pkg::ST_SUB_CHK: begin
        if (sts.can_commit) begin
          state_nxt = sts.idx_last ? mcps_pkg::ST_FLUSH : mcps_pkg::ST_SUB_RD;
        end
      end
      mcps_pkg::ST_FLUSH: begin
        if (sts.out_free) begin
          state_nxt = mcps_pkg::ST_IDLE;
        end
      end
      mcps_pkg::ST_EMPTY: begin
        if (sts.out_free) begin
          state_nxt = mcps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mcps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      mcps_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == mcps_pkg::KIND_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.adv_start = 1'b1;
          end
        end
      end
      mcps_pkg::ST_MIN: begin
        cmd.min_step = 1'b1;
        cmd.idx_inc  = !sts.idx_last;
      end
      mcps_pkg::ST_MIN_END: cmd.sub_start = 1'b1;
      mcps_pkg::ST_SUB_RD: begin
        if (sts.any) begin
          if (sts.cur_valid) begin
            cmd.sub_rd = 1'b1;
          end else begin
            cmd.idx_inc = !sts.idx_last;
          end
        end
      end
      mcps_pkg::ST_SUB_CHK: begin
        if (sts.can_commit) begin
          cmd.sub_commit = 1'b1;
          cmd.idx_inc    = !sts.idx_last;
        end
      end
      mcps_pkg::ST_FLUSH: cmd.flush = sts.out_free;
      mcps_pkg::ST_EMPTY: cmd.emit_empty = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/mcps_dp.sv =====
// mcps_dp: channel table (valid flops, base and remaining memories), minimum
// search, countdown update and result register. Depends on mcps_pkg.
`default_nettype none
module mcps_dp #(
  parameter int unsigned NUM_CHANNELS = 32
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire  [mcps_pkg::ID_W-1:0]         in_physical_id,
  input  wire  [mcps_pkg::PERIOD_W-1:0]     in_period,
  input  mcps_pkg::cmd_t                    cmd,
  output mcps_pkg::sts_t                    sts,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [mcps_pkg::PERIOD_W-1:0]     out_sleep_time,
  output logic [mcps_pkg::ID_W-1:0]         out_fired_id,
  output logic                              out_table_empty,
  output logic                              out_last
);

  localparam int unsigned IDXW    = $clog2(NUM_CHANNELS);
  localparam int unsigned SCAN    = (NUM_CHANNELS < 32) ? NUM_CHANNELS : 32;
  localparam int unsigned LastIdx = SCAN - 1;
  localparam int unsigned IDEXTW  = (IDXW > mcps_pkg::ID_W) ? IDXW : mcps_pkg::ID_W;

  logic [NUM_CHANNELS-1:0]          valid_r;
  logic [mcps_pkg::PERIOD_W-1:0]    base_mem [NUM_CHANNELS];
  logic [mcps_pkg::PERIOD_W-1:0]    rem_mem  [NUM_CHANNELS];
  logic [mcps_pkg::PERIOD_W-1:0]    base_rd_r, rem_rd_r;
  logic [mcps_pkg::PERIOD_W-1:0]    min_r;
  logic                             any_r;
  logic                             cmp_pend_r;
  logic [IDXW-1:0]                  idx_r;
  logic                             hold_vld_r;
  logic [IDXW-1:0]                  hold_idx_r;

  logic                             out_valid_r;
  logic [mcps_pkg::PERIOD_W-1:0]    out_sleep_r;
  logic [mcps_pkg::ID_W-1:0]        out_id_r;
  logic                             out_empty_r, out_last_r;

  logic [IDEXTW-1:0]                id_ext;
  logic [IDXW-1:0]                  load_idx;
  logic                             load_ok;
  logic [mcps_pkg::PERIOD_W-1:0]    diff;
  logic                             fired;
  logic                             out_free;
  logic                             push;

  assign id_ext   = IDEXTW'(in_physical_id);
  assign load_idx = id_ext[IDXW-1:0];
  assign load_ok  = cmd.load && (in_physical_id != '0)
                    && (32'(in_physical_id) < 32'(NUM_CHANNELS));

  assign diff     = rem_rd_r - min_r;
  assign fired    = (diff == '0);
  assign out_free = !out_valid_r || out_ready;
  assign push     = cmd.flush || cmd.emit_empty
                    || (cmd.sub_commit && fired && hold_vld_r);

  assign sts.idx_last   = (idx_r == IDXW'(LastIdx));
  assign sts.cur_valid  = valid_r[idx_r];
  assign sts.any        = any_r;
  assign sts.can_commit = !fired || !hold_vld_r || out_free;
  assign sts.out_free   = out_free;

  // table memories
  always_ff @(posedge clk) begin
    if (load_ok) begin
      base_mem[load_idx] <= in_period;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      rem_mem[load_idx] <= in_period;
    end else if (cmd.sub_commit) begin
      rem_mem[idx_r] <= fired ? base_rd_r : diff;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.min_step || cmd.sub_rd) begin
      rem_rd_r  <= rem_mem[idx_r];
      base_rd_r <= base_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (load_ok) begin
      valid_r[load_idx] <= 1'b1;
    end
  end

  // scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      cmp_pend_r <= 1'b0;
      any_r      <= 1'b0;
      hold_vld_r <= 1'b0;
    end else begin
      if (cmd.adv_start || cmd.sub_start) begin
        idx_r <= IDXW'(1);
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + IDXW'(1);
      end
      cmp_pend_r <= cmd.min_step && valid_r[idx_r];
      if (cmd.adv_start) begin
        any_r      <= 1'b0;
        hold_vld_r <= 1'b0;
      end else begin
        if (cmp_pend_r) begin
          any_r <= 1'b1;
        end
        if (cmd.sub_commit && fired) begin
          hold_vld_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.adv_start) begin
      min_r <= '0;
    end else if (cmp_pend_r && (!any_r || rem_rd_r < min_r)) begin
      min_r <= rem_rd_r;
    end
    if (cmd.sub_commit && fired) begin
      hold_idx_r <= idx_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_sleep_r <= min_r;
      out_id_r    <= cmd.emit_empty ? '0 : mcps_pkg::ID_W'(hold_idx_r);
      out_empty_r <= cmd.emit_empty;
      out_last_r  <= cmd.emit_empty || cmd.flush;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sleep_time  = out_sleep_r;
  assign out_fired_id    = out_id_r;
  assign out_table_empty = out_empty_r;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire

// ===== src/multi_channel_period_scheduler_top.sv =====
// multi_channel_period_scheduler_top: periodic countdown scheduler, top level.
// Depends on mcps_pkg, mcps_ctrl and mcps_dp.
//
//   channel | ports                                          | dir
//   in      | in_valid/in_ready, in_kind, in_physical_id,     | sink
//           | in_period                                      |
//   out     | out_valid/out_ready, out_sleep_time,           | source
//           | out_fired_id, out_table_empty, out_last        |
//
// A load is taken in the idle state. An advance makes a pipelined minimum pass over
// channels 1..L (L = min(NUM_CHANNELS,32)-1), then an update pass that visits
// each idle channel in ST_SUB_RD and each live one in ST_SUB_RD and ST_SUB_CHK,
// then a flush; on an empty table it skips the update and emits an empty result.
// Reset clears the valid flops, the control state and the result valid flag only.
// A stalled result port holds the update pass at the next expiring channel.
`default_nettype none
module multi_channel_period_scheduler_top #(
  parameter int unsigned NUM_CHANNELS = 32
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire                               in_kind,
  input  wire  [mcps_pkg::ID_W-1:0]         in_physical_id,
  input  wire  [mcps_pkg::PERIOD_W-1:0]     in_period,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [mcps_pkg::PERIOD_W-1:0]     out_sleep_time,
  output logic [mcps_pkg::ID_W-1:0]         out_fired_id,
  output logic                              out_table_empty,
  output logic                              out_last
);

  mcps_pkg::cmd_t cmd;
  mcps_pkg::sts_t sts;

  mcps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mcps_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_physical_id  (in_physical_id),
    .in_period       (in_period),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sleep_time  (out_sleep_time),
    .out_fired_id    (out_fired_id),
    .out_table_empty (out_table_empty),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire
